// ===== rtl/core/mpv_pkg.sv =====
// shared types, constants and sha-256 helpers for the merkle proof verifier
`default_nettype none
package mpv_pkg;

  localparam int unsigned MaxLeafBytes = 255;
  localparam int unsigned TreeLevels   = 4;
  localparam int unsigned HashBytes    = 32;
  localparam int unsigned MaxListBytes = 255;

  typedef enum logic [1:0] {
    CMD_LEAF  = 2'd0,
    CMD_LIST  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_META  = 2'd1,
    ST_UNEXP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ROOT0 = 2'd0,
    REG_ROOT1 = 2'd1,
    REG_ROOT2 = 2'd2,
    REG_ROOT3 = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       verified;
    logic [2:0] level_now;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_COMP,
    S_PAD,
    S_LEN,
    S_DONE,
    S_OUT
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       take_byte;   // store byte, update match and count
    logic       start_comp;  // begin 64-round compression
    logic       pad_first;   // write 0x80 and zero tail
    logic       pad_len;     // write length words
    logic       zero_buf;
    logic       load_hash;   // chain value to node hash
    logic       stream_rst;
    logic       clear_all;
  } dp_cmd_t;

  typedef struct packed {
    logic        busy;
    logic        block_full;  // last stored byte closed a 64-byte block
    logic        pad_two;     // padding spills into a second block
    logic        overflow;
    logic [15:0] count;
    logic        hash_found;
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    sha_k = k[i];
  endfunction

  localparam logic [255:0] ShaIv = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage
`default_nettype wire

// ===== rtl/core/mpv_datapath.sv =====
// message buffer, match tracking and iterative sha-256 compression unit
`default_nettype none
module mpv_datapath
  import mpv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire dp_cmd_t    dcmd,
  input  wire logic [7:0] data_byte,
  output dp_stat_t        stat,
  output logic [255:0]    node_hash
);

  logic [31:0]  wbuf [16];
  logic [255:0] chain;
  logic [255:0] work;
  logic [6:0]   round;
  logic         busy;
  logic [15:0]  count;
  logic         overflow;
  logic         hash_found;
  logic         group_equal;
  logic         block_full;

  logic [4:0]  gpos;
  logic [7:0]  node_b;
  logic        byte_eq;
  logic [5:0]  pos;
  logic [5:0]  pad_pos;
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;

  assign gpos   = count[4:0];
  assign node_b = node_hash[8'd255 - {gpos, 3'd0} -: 8];
  assign byte_eq = (data_byte == node_b);
  assign pos    = count[5:0];
  assign pad_pos = count[5:0];

  assign {a, b, c, d, e, f, g, h} = work;
  assign t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + sha_k(round[5:0]) + wbuf[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  assign s0 = rotr(wbuf[1], 7) ^ rotr(wbuf[1], 18) ^ (wbuf[1] >> 3);
  assign s1 = rotr(wbuf[14], 17) ^ rotr(wbuf[14], 19) ^ (wbuf[14] >> 10);
  assign wn = wbuf[0] + s0 + wbuf[9] + s1;

  // schedule kept as a rolling window in the buffer; it is rewritten after each block
  always_ff @(posedge clk) begin
    if (busy) begin
      for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i + 1];
      wbuf[15] <= wn;
    end else if (dcmd.take_byte) begin
      wbuf[pos[5:2]][8'd31 - {pos[1:0], 3'd0} -: 8] <= data_byte;
    end else if (dcmd.pad_first) begin
      for (int i = 0; i < 16; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (6'(4 * i + j) == pad_pos) wbuf[i][31 - 8 * j -: 8] <= 8'h80;
          else if (6'(4 * i + j) > pad_pos) wbuf[i][31 - 8 * j -: 8] <= 8'h00;
        end
      end
    end else if (dcmd.zero_buf) begin
      for (int i = 0; i < 16; i++) wbuf[i] <= '0;
    end else if (dcmd.pad_len) begin
      wbuf[14] <= '0;
      wbuf[15] <= {13'd0, count, 3'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
      chain <= ShaIv;
      node_hash <= '0;
      count <= '0;
      overflow <= 1'b0;
      hash_found <= 1'b0;
      group_equal <= 1'b1;
      block_full <= 1'b0;
    end else begin
      if (busy) begin
        work <= {t1 + t2, a, b, c, d + t1, e, f, g};
        round <= round + 7'd1;
        if (round == 7'd63) begin
          busy <= 1'b0;
          chain <= {chain[255:224] + t1 + t2, chain[223:192] + a, chain[191:160] + b,
                    chain[159:128] + c, chain[127:96] + d + t1, chain[95:64] + e,
                    chain[63:32] + f, chain[31:0] + g};
        end
      end else if (dcmd.start_comp) begin
        busy <= 1'b1;
        round <= '0;
        work <= chain;
      end
      if (dcmd.take_byte) begin
        block_full <= (pos == 6'd63);
        if (!byte_eq) group_equal <= 1'b0;
        if (gpos == 5'd31) begin
          if (group_equal && byte_eq) hash_found <= 1'b1;
          group_equal <= 1'b1;
        end
        if (count == 16'hffff) overflow <= 1'b1;
        else count <= count + 16'd1;
      end
      if (dcmd.load_hash) node_hash <= chain;
      if (dcmd.clear_all) node_hash <= '0;
      if (dcmd.stream_rst) begin
        chain <= ShaIv;
        count <= '0;
        overflow <= 1'b0;
        hash_found <= 1'b0;
        group_equal <= 1'b1;
        block_full <= 1'b0;
      end
    end
  end

  assign stat = '{busy: busy, block_full: block_full, pad_two: (count[5:0] >= 6'd56),
                  overflow: overflow, count: count, hash_found: hash_found};

endmodule
`default_nettype wire

// ===== rtl/core/mpv_ctrl.sv =====
// request sequencing, acceptance checks and result register
`default_nettype none
module mpv_ctrl
  import mpv_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire in_item_t     in_item,
  output logic              out_valid,
  input  wire logic         out_stall,
  output out_item_t         out_item,
  input  wire logic [255:0] root,
  input  wire logic [255:0] node_hash,
  input  wire dp_stat_t     stat,
  output dp_cmd_t           dcmd,
  output logic [7:0]        req_byte
);

  state_t     state, state_next;
  in_item_t   req;
  logic [2:0] level;
  logic [2:0] level_next;
  out_item_t  res_next;
  logic       res_load;
  logic       pad2;
  logic       pad2_next;
  logic       overlong;
  logic       list_ok;

  assign req_byte = req.data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      out_valid <= 1'b0;
      pad2 <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      pad2 <= pad2_next;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) req <= in_item;
    if (res_load) out_item <= res_next;
  end

  always_comb begin
    if (req.cmd == CMD_LEAF) overlong = stat.overflow || (stat.count > 16'(MaxLeafBytes));
    else overlong = stat.overflow || (stat.count > 16'(MaxListBytes));
  end
  assign list_ok = (level >= 3'd1) && (level <= 3'(TreeLevels)) && !overlong &&
                   (stat.count[4:0] == 5'd0) && stat.hash_found;

  always_comb begin
    state_next = state;
    level_next = level;
    pad2_next  = pad2;
    dcmd       = '0;
    res_load   = 1'b0;
    res_next   = '{status: ST_OK, verified: 1'b0, level_now: level};
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = out_valid;
        if (in_valid && !out_valid) state_next = S_BYTE;
      end
      S_BYTE: begin
        unique case (cmd_t'(req.cmd))
          CMD_CLEAR: begin
            dcmd.clear_all = 1'b1;
            dcmd.stream_rst = 1'b1;
            level_next = '0;
            res_next.level_now = '0;
            res_load = 1'b1;
            state_next = S_IDLE;
          end
          CMD_CHECK: begin
            res_next.verified = (level == 3'(TreeLevels + 1)) && (node_hash == root);
            res_load = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            dcmd.take_byte = 1'b1;
            state_next = S_COMP;
          end
        endcase
      end
      S_COMP: begin
        // block completed by this byte is folded in before anything else
        if (stat.block_full && !stat.busy && !pad2) begin
          dcmd.start_comp = 1'b1;
          pad2_next = 1'b1;
        end else if (!stat.busy) begin
          pad2_next = 1'b0;
          if (!req.final_byte) state_next = S_IDLE;
          else if (req.cmd == CMD_LEAF && overlong) begin
            res_next.status = ST_META; res_load = 1'b1;
            dcmd.stream_rst = 1'b1; state_next = S_IDLE;
          end else if (req.cmd == CMD_LEAF && level != 3'd0) begin
            res_next.status = ST_UNEXP; res_load = 1'b1;
            dcmd.stream_rst = 1'b1; state_next = S_IDLE;
          end else if (req.cmd == CMD_LIST && !list_ok) begin
            res_next.status = ST_META; res_load = 1'b1;
            dcmd.stream_rst = 1'b1; state_next = S_IDLE;
          end else begin
            dcmd.pad_first = 1'b1;
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (stat.pad_two && !pad2) begin
          dcmd.start_comp = 1'b1;
          pad2_next = 1'b1;
        end else if (!stat.busy) begin
          if (pad2) dcmd.zero_buf = 1'b1;
          pad2_next = 1'b0;
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        dcmd.pad_len = 1'b1;
        dcmd.start_comp = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.busy) begin
          dcmd.load_hash = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        level_next = level + 3'd1;
        res_next.level_now = level + 3'd1;
        res_load = 1'b1;
        dcmd.stream_rst = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/merkle_proof_verifier_sha256_top.sv =====
// merkle proof verifier top level: register port, controller and datapath
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_stall
//  out     | out | out_item_t | out_valid / out_stall
// a byte closing a 64-byte block adds the compression rounds, one round a cycle in the
// shared unit. a final byte adds padding and one or two further compressions.
// rst is synchronous and clears the level, hash and roots.
// the result register holds while out_stall is high; a new request waits for it.
`default_nettype none
module merkle_proof_verifier_sha256_top
  import mpv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  logic [63:0]  root_word [4];
  logic [255:0] node_hash;
  dp_cmd_t      dcmd;
  dp_stat_t     stat;
  reg_idx_t     ridx;
  logic [7:0]   req_byte;

  assign pready = 1'b1;
  assign ridx = reg_idx_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) root_word[i] <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      root_word[ridx] <= pwdata;
    end
  end

  assign prdata = (paddr[2:0] == 3'd0) ? root_word[ridx] : '0;

  mpv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_item, .out_valid, .out_stall, .out_item,
    .root({root_word[0], root_word[1], root_word[2], root_word[3]}),
    .node_hash, .stat, .dcmd, .req_byte
  );

  mpv_datapath u_dp (
    .clk, .rst, .dcmd, .data_byte(req_byte), .stat, .node_hash
  );

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.level_now <= 3'(TreeLevels + 1))
    else $error("level out of range");
  a_verified_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.verified) |-> out_item.status == ST_OK)
    else $error("verified with error status");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !dcmd.take_byte)
    else $error("byte stored during compression");

endmodule
`default_nettype wire

// ===== tb/tb_merkle_proof_verifier_sha256_top.sv =====
// testbench for the merkle proof verifier: proof sequences, noise and a scoreboard
module tb_merkle_proof_verifier_sha256_top;
  import mpv_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam bit [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam bit [31:0] START_CV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  class proof_tracker;
    bit [63:0]  root [4];
    bit [2:0]   level;
    bit [63:0]  node [4];
    bit [31:0]  cv [8];
    bit [31:0]  blk [16];
    bit [15:0]  count;
    bit         found;
    bit         grp_eq;
    bit         ovf;
    out_item_t  expected_verdicts [$];
    int         errors;
    int         verdicts;
    int         verified_seen;

    function new();
      foreach (root[i]) root[i] = '0;
      foreach (node[i]) node[i] = '0;
      foreach (blk[i]) blk[i] = '0;
      level = '0;
      errors = 0;
      verdicts = 0;
      verified_seen = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      foreach (cv[i]) cv[i] = START_CV[i];
      count = '0;
      found = 1'b0;
      grp_eq = 1'b1;
      ovf = 1'b0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
      e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
      for (int i = 0; i < 64; i++) begin
        t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + RND_K[i] + w[i];
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d;
      cv[4] += e; cv[5] += f; cv[6] += g; cv[7] += h;
    endfunction

    function void put_b(int pos, bit [7:0] v);
      blk[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = v;
    endfunction

    function bit [7:0] node_b(int j);
      return node[(j >> 3) & 3][(7 - (j & 7)) * 8 +: 8];
    endfunction

    // pad, length words, final compression, digest into the node hash
    function void close_digest();
      int pos;
      pos = count & 63;
      put_b(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) put_b(i, 8'h00);
      if (pos >= 56) begin
        compress();
        foreach (blk[i]) blk[i] = '0;
      end
      blk[14] = '0;
      blk[15] = {13'd0, count, 3'b000};
      compress();
      for (int i = 0; i < 4; i++) node[i] = {cv[2*i], cv[2*i+1]};
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      int gpos;
      bit overlong;
      r = '0;
      if (it.cmd == CMD_CLEAR) begin
        level = '0;
        foreach (node[i]) node[i] = '0;
        restart_stream();
      end else if (it.cmd == CMD_CHECK) begin
        r.verified = (level == TreeLevels + 1) && node[0] == root[0] && node[1] == root[1]
                     && node[2] == root[2] && node[3] == root[3];
      end else begin
        gpos = count % HashBytes;
        if (it.data_byte != node_b(gpos)) grp_eq = 1'b0;
        if (gpos == HashBytes - 1) begin
          if (grp_eq) found = 1'b1;
          grp_eq = 1'b1;
        end
        put_b(count & 63, it.data_byte);
        if ((count & 63) == 63) compress();
        if (count == 16'hffff) ovf = 1'b1;
        else count++;
        if (!it.final_byte) return;
        if (it.cmd == CMD_LEAF) begin
          overlong = ovf || count > MaxLeafBytes;
          if (overlong) r.status = ST_META;
          else if (level != 0) r.status = ST_UNEXP;
          else begin
            close_digest();
            level = 3'd1;
          end
        end else begin
          overlong = ovf || count > MaxListBytes;
          if (level < 1 || level > TreeLevels) r.status = ST_META;
          else if (overlong) r.status = ST_META;
          else if (count % HashBytes != 0) r.status = ST_META;
          else if (!found) r.status = ST_META;
          else begin
            close_digest();
            level = level + 3'd1;
          end
        end
        restart_stream();
      end
      r.level_now = level;
      expected_verdicts.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      verdicts++;
      if (got.verified) verified_seen++;
      if (expected_verdicts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = expected_verdicts.pop_front();
      if (got.status !== exp.status || got.verified !== exp.verified ||
          got.level_now !== exp.level_now) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected status %0d verified %0d level %0d, got %0d %0d %0d",
                   exp.status, exp.verified, exp.level_now,
                   got.status, got.verified, got.level_now);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  proof_tracker tracker;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  int unsigned  hold_left;
  int unsigned  quiet_cycles;
  int           requests;
  int           proofs_done;

  merkle_proof_verifier_sha256_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_item);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_merkle_proof_verifier_sha256_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_request(cmd_t cmd, bit [7:0] data, bit fin);
    in_item_t it;
    it.cmd = cmd;
    it.data_byte = data;
    it.final_byte = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_request(it);
    requests++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.root[idx] = value;
    @(posedge clk);
  endtask

  task automatic set_root(bit [63:0] w0, bit [63:0] w1, bit [63:0] w2, bit [63:0] w3);
    wait_idle();
    write_reg(REG_ROOT0, w0);
    write_reg(REG_ROOT1, w1);
    write_reg(REG_ROOT2, w2);
    write_reg(REG_ROOT3, w3);
  endtask

  // byte stream; inner bytes carry either stream cmd, the last one decides
  task automatic send_stream(bit [7:0] bytes [$], cmd_t last_cmd);
    for (int i = 0; i < bytes.size(); i++) begin
      if (i == bytes.size() - 1) send_request(last_cmd, bytes[i], 1'b1);
      else send_request($urandom_range(3) == 0 ? CMD_LEAF : CMD_LIST, bytes[i], 1'b0);
    end
  endtask

  task automatic run_proof();
    bit [7:0] bytes [$];
    int len, groups, pos, flaw;
    send_request(CMD_CLEAR, 8'($urandom), 1'($urandom));
    len = ($urandom_range(9) == 0) ? $urandom_range(200, 256) : $urandom_range(1, 40);
    bytes.delete();
    repeat (len) bytes.push_back(8'($urandom));
    send_stream(bytes, CMD_LEAF);
    for (int lvl = 0; lvl < TreeLevels; lvl++) begin
      groups = ($urandom_range(7) == 0) ? $urandom_range(3, 7) : $urandom_range(1, 2);
      pos = $urandom_range(groups - 1);
      flaw = ($urandom_range(19) == 0) ? $urandom_range(1, 3) : 0;
      if (flaw == 3) groups = 8;
      bytes.delete();
      for (int g = 0; g < groups; g++)
        for (int j = 0; j < HashBytes; j++)
          bytes.push_back(g == pos ? tracker.node_b(j) : 8'($urandom));
      if (flaw == 1) bytes[pos * HashBytes + $urandom_range(31)] ^= 8'(1 << $urandom_range(7));
      if (flaw == 2) void'(bytes.pop_back());
      send_stream(bytes, CMD_LIST);
      if ($urandom_range(5) == 0) send_request(CMD_CHECK, 8'($urandom), 1'($urandom));
    end
    send_request(CMD_CHECK, 8'($urandom), 1'($urandom));
    // a verified proof: load the current hash as the root and check again
    if (tracker.level == TreeLevels + 1) begin
      set_root(tracker.node[0], tracker.node[1], tracker.node[2], tracker.node[3]);
      send_request(CMD_CHECK, 8'($urandom), 1'($urandom));
      bytes.delete();
      repeat (HashBytes) bytes.push_back(8'($urandom));
      send_stream(bytes, CMD_LIST);
      proofs_done++;
    end
  endtask

  task automatic send_noise(int n);
    repeat (n) send_request(cmd_t'($urandom_range(3)), 8'($urandom), ($urandom_range(3) == 0));
  endtask

  initial begin
    bit [7:0] bytes [$];
    int phase_start;
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    requests = 0;
    proofs_done = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed cases
    send_request(CMD_CHECK, 8'h00, 1'b1);
    send_request(CMD_LIST, 8'hff, 1'b1);
    send_request(CMD_LEAF, 8'hff, 1'b1);
    send_request(CMD_LEAF, 8'h00, 1'b1);
    send_request(CMD_LIST, 8'h5a, 1'b0);
    send_request(CMD_CHECK, 8'hff, 1'b0);
    send_request(CMD_LIST, 8'ha5, 1'b1);
    send_request(CMD_LEAF, 8'h12, 1'b0);
    send_request(CMD_CLEAR, 8'hff, 1'b0);
    send_request(CMD_LIST, 8'h34, 1'b1);
    send_request(CMD_LEAF, 8'h80, 1'b0);
    send_request(CMD_LIST, 8'h01, 1'b1);
    send_request(CMD_CLEAR, 8'h00, 1'b1);
    bytes.delete();
    repeat (MaxLeafBytes) bytes.push_back(8'($urandom));
    send_stream(bytes, CMD_LEAF);
    send_request(CMD_CLEAR, 8'h00, 1'b0);
    bytes.push_back(8'h77);
    send_stream(bytes, CMD_LEAF);
    send_request(CMD_CHECK, 8'h00, 1'b0);

    set_root('1, '1, '1, '1);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 66; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 66; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (phase == 0) begin
        // long hold-off while requests keep coming
        hold_left = HOLD_CYCLES;
        repeat (12) send_request(CMD_CHECK, 8'($urandom), 1'($urandom));
      end
      phase_start = requests;
      while (requests - phase_start < 210) begin
        run_proof();
        send_noise($urandom_range(5, 15));
      end
      if (phase == 1) set_root('0, '0, '0, '0);
      else set_root({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
      send_request(CMD_CHECK, 8'($urandom), 1'($urandom));
    end

    wait_idle();
    $display("%0d requests, %0d results checked, %0d verified checks, %0d full proofs",
             requests, tracker.verdicts, tracker.verified_seen, proofs_done);
    $display("%0d mismatches", tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb_merkle_proof_verifier_sha256_top OK");
    end else begin
      $display("tb_merkle_proof_verifier_sha256_top NOT OK");
    end
    $finish;
  end

endmodule
